// ----- rtl/rhmw_pkg.sv -----
package rhmw_pkg;

   // item function codes
   localparam logic [1:0] FUNC_MARK  = 2'd0;
   localparam logic [1:0] FUNC_STEP  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // headings
   localparam logic [1:0] HEAD_SOUTH = 2'd0;
   localparam logic [1:0] HEAD_WEST  = 2'd1;
   localparam logic [1:0] HEAD_NORTH = 2'd2;
   localparam logic [1:0] HEAD_EAST  = 2'd3;

   // turns, added to the heading
   localparam logic [1:0] TURN_AHEAD = 2'd0;
   localparam logic [1:0] TURN_RIGHT = 2'd1;
   localparam logic [1:0] TURN_BACK  = 2'd2;
   localparam logic [1:0] TURN_LEFT  = 2'd3;

   // register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic [8:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic load_item;
      logic restart;
      logic clr_wr;
      logic mark_wr;
      logic scan_start;
      logic scan_next;
      logic rd_scan;
      logic try_start;
      logic try_next;
      logic rd_nb;
      logic commit_entry;
      logic commit_move;
      logic set_stuck;
      logic set_noentry;
      logic rsp_load;
   } rhmw_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       started;
      logic       done;
      logic       scan_last;
      logic       cell_wall;
      logic       nb_valid;
      logic       try_last;
      logic       clr_last;
   } rhmw_status_type;

   // right, ahead, left, back
   function automatic logic [1:0] try_heading(input logic [1:0] facing,
                                              input logic [1:0] k);
      logic [1:0] turn;
      case (k)
         2'd0:    turn = TURN_RIGHT;
         2'd1:    turn = TURN_AHEAD;
         2'd2:    turn = TURN_LEFT;
         default: turn = TURN_BACK;
      endcase
      return facing + turn;
   endfunction

endpackage

// ----- rtl/right_hand_maze_walker.sv -----
// Right-hand wall-following maze walker.
// req channel (valid/stall): one beat carries func, wall_row, wall_col.
//   mark   - sets one wall cell; no response beat.
//   step   - at most one move; exactly one response beat (pos_row, pos_col,
//            reached_exit, stuck).
//   clear  - wipes the wall map and restarts the walk; no response beat.
// rsp channel (valid/stall): the response sits in an output register and
//   holds while rsp_stall is high. The next request beat may be taken while
//   it waits; a following step then parks until the register frees up.
// csr port (APB-style): rows_in_use at 0x0, cols_in_use at 0x4, 9 bits each.
// Sequence: a step already at the exit goes straight to the response; a
//   normal step reads the in-grid neighbours one at a time and skips those
//   off the grid; a step before entry scans row 0 one column at a time. A mark
//   holds req_stall while it writes. The single read port of the wall map
//   serves one cell at a time.
// Reset (and clear): the map is swept to open, one cell a cycle, over
//   min(MAX_ROWS,256) * 2**clog2(min(MAX_COLS,256)) cells (65536 by default)
//   with req_stall high; csr writes are still taken.
module right_hand_maze_walker #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_wall_row,
   input  logic [7:0]  req_wall_col,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pos_row,
   output logic [7:0]  rsp_pos_col,
   output logic        rsp_reached_exit,
   output logic        rsp_stuck,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // the walk never sees more than a 256 x 256 grid
   localparam int ROW_LIM = (MAX_ROWS < 256) ? MAX_ROWS : 256;
   localparam int COL_LIM = (MAX_COLS < 256) ? MAX_COLS : 256;

   rhmw_pkg::rhmw_cmd_type    cmd;
   rhmw_pkg::rhmw_status_type status;

   logic [8:0] rows_in_use_ff, rows_in_use_in;
   logic [8:0] cols_in_use_ff, cols_in_use_in;
   logic       csr_wr;
   logic       csr_idx;

   // zero-wait APB: write lands on the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      rows_in_use_in = rows_in_use_ff;
      cols_in_use_in = cols_in_use_ff;
      if (csr_wr) begin
         if (csr_idx == rhmw_pkg::CSR_ROWS) begin
            rows_in_use_in = csr_pwdata[8:0];
         end else begin
            cols_in_use_in = csr_pwdata[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= rhmw_pkg::SIZE_RESET;
         cols_in_use_ff <= rhmw_pkg::SIZE_RESET;
      end else begin
         rows_in_use_ff <= rows_in_use_in;
         cols_in_use_ff <= cols_in_use_in;
      end
   end

   // readback, zero-extended
   assign csr_prdata = (csr_idx == rhmw_pkg::CSR_COLS) ? {23'd0, cols_in_use_ff}
                                                        : {23'd0, rows_in_use_ff};

   // sequencer: sweep, decode, row-0 scan, neighbour tries, response
   rhmw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // wall map, walker position and heading, response payload
   rhmw_dp #(
      .ROW_LIM(ROW_LIM),
      .COL_LIM(COL_LIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rows_in_use     (rows_in_use_ff),
      .cols_in_use     (cols_in_use_ff),
      .req_func        (req_func),
      .req_wall_row    (req_wall_row),
      .req_wall_col    (req_wall_col),
      .rsp_pos_row     (rsp_pos_row),
      .rsp_pos_col     (rsp_pos_col),
      .rsp_reached_exit(rsp_reached_exit),
      .rsp_stuck       (rsp_stuck)
   );

endmodule

// ----- rtl/rhmw_ram.sv -----
module rhmw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rhmw_dp.sv -----
module rhmw_dp #(
   parameter int ROW_LIM = 256,
   parameter int COL_LIM = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rhmw_pkg::rhmw_cmd_type    cmd,
   output rhmw_pkg::rhmw_status_type status,
   input  logic [8:0]                rows_in_use,
   input  logic [8:0]                cols_in_use,
   input  logic [1:0]                req_func,
   input  logic [7:0]                req_wall_row,
   input  logic [7:0]                req_wall_col,
   output logic [7:0]                rsp_pos_row,
   output logic [7:0]                rsp_pos_col,
   output logic                      rsp_reached_exit,
   output logic                      rsp_stuck
);

   localparam int RB    = $clog2(ROW_LIM);
   localparam int CB    = $clog2(COL_LIM);
   localparam int AW    = RB + CB;
   localparam int DEPTH = ROW_LIM * (2 ** CB);

   function automatic logic [8:0] sat_size(input logic [8:0] v, input logic [8:0] lim);
      logic [8:0] s;
      if (v == 9'd0) begin
         s = 9'd1;
      end else if (v > lim) begin
         s = lim;
      end else begin
         s = v;
      end
      return s;
   endfunction

   // walker and sweep state
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]    cur_row_ff, cur_row_in;
   logic [7:0]    cur_col_ff, cur_col_in;
   logic [1:0]    facing_ff, facing_in;
   logic          started_ff, started_in;
   logic [7:0]    scan_col_ff, scan_col_in;
   logic [1:0]    try_ff, try_in;
   logic          stuck_ff, stuck_in;
   logic          noentry_ff, noentry_in;

   // latched item and result payload
   logic [1:0] func_ff;
   logic [7:0] wall_row_ff;
   logic [7:0] wall_col_ff;
   logic [7:0] pos_row_ff;
   logic [7:0] pos_col_ff;
   logic       reached_ff;
   logic       rstuck_ff;

   logic [8:0] nrows, ncols, last_row;
   logic [1:0] nb_head;
   logic [8:0] nb_row, nb_col;
   logic       nb_under;
   logic       nb_valid;
   logic       done;
   logic       mark_ok;

   logic          wr_en, rd_en, wr_data, rd_data;
   logic [AW-1:0] wr_addr, rd_addr, mark_addr, nb_addr, scan_addr;

   assign nrows    = sat_size(rows_in_use, 9'(ROW_LIM));
   assign ncols    = sat_size(cols_in_use, 9'(COL_LIM));
   assign last_row = nrows - 9'd1;
   assign done     = {1'b0, cur_row_ff} >= last_row;

   // neighbour in the heading under test
   always_comb begin
      nb_head  = rhmw_pkg::try_heading(facing_ff, try_ff);
      nb_row   = {1'b0, cur_row_ff};
      nb_col   = {1'b0, cur_col_ff};
      nb_under = 1'b0;
      case (nb_head)
         rhmw_pkg::HEAD_SOUTH: nb_row = {1'b0, cur_row_ff} + 9'd1;
         rhmw_pkg::HEAD_WEST: begin
            nb_under = (cur_col_ff == 8'd0);
            nb_col   = {1'b0, cur_col_ff} - 9'd1;
         end
         rhmw_pkg::HEAD_NORTH: begin
            nb_under = (cur_row_ff == 8'd0);
            nb_row   = {1'b0, cur_row_ff} - 9'd1;
         end
         default: nb_col = {1'b0, cur_col_ff} + 9'd1;
      endcase
      nb_valid = !nb_under && (nb_row < nrows) && (nb_col < ncols);
   end

   assign nb_addr   = {nb_row[RB-1:0], nb_col[CB-1:0]};
   assign scan_addr = {{RB{1'b0}}, scan_col_ff[CB-1:0]};
   assign mark_addr = {wall_row_ff[RB-1:0], wall_col_ff[CB-1:0]};
   // cells beyond the stored grid are never read back
   assign mark_ok   = ({1'b0, wall_row_ff} < 9'(ROW_LIM))
                   && ({1'b0, wall_col_ff} < 9'(COL_LIM));

   assign wr_en   = cmd.clr_wr | (cmd.mark_wr & mark_ok);
   assign wr_addr = cmd.clr_wr ? clr_addr_ff : mark_addr;
   assign wr_data = !cmd.clr_wr;
   assign rd_en   = cmd.rd_scan | cmd.rd_nb;
   assign rd_addr = cmd.rd_nb ? nb_addr : scan_addr;

   rhmw_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_wall_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      clr_addr_in = clr_addr_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      facing_in   = facing_ff;
      started_in  = started_ff;
      scan_col_in = scan_col_ff;
      try_in      = try_ff;
      stuck_in    = stuck_ff;
      noentry_in  = noentry_ff;
      if (cmd.restart) begin
         clr_addr_in = '0;
         cur_row_in  = 8'd0;
         cur_col_in  = 8'd0;
         facing_in   = rhmw_pkg::HEAD_SOUTH;
         started_in  = 1'b0;
      end
      if (cmd.clr_wr) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.load_item) begin
         stuck_in   = 1'b0;
         noentry_in = 1'b0;
      end
      if (cmd.scan_start) begin
         scan_col_in = 8'd0;
      end
      if (cmd.scan_next) begin
         scan_col_in = scan_col_ff + 8'd1;
      end
      if (cmd.try_start) begin
         try_in = 2'd0;
      end
      if (cmd.try_next) begin
         try_in = try_ff + 2'd1;
      end
      if (cmd.commit_entry) begin
         cur_row_in = 8'd0;
         cur_col_in = scan_col_ff;
         facing_in  = rhmw_pkg::HEAD_SOUTH;
         started_in = 1'b1;
      end
      if (cmd.commit_move) begin
         cur_row_in = nb_row[7:0];
         cur_col_in = nb_col[7:0];
         facing_in  = nb_head;
      end
      if (cmd.set_stuck) begin
         stuck_in = 1'b1;
      end
      if (cmd.set_noentry) begin
         stuck_in   = 1'b1;
         noentry_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         cur_row_ff  <= 8'd0;
         cur_col_ff  <= 8'd0;
         facing_ff   <= rhmw_pkg::HEAD_SOUTH;
         started_ff  <= 1'b0;
         scan_col_ff <= 8'd0;
         try_ff      <= 2'd0;
         stuck_ff    <= 1'b0;
         noentry_ff  <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         facing_ff   <= facing_in;
         started_ff  <= started_in;
         scan_col_ff <= scan_col_in;
         try_ff      <= try_in;
         stuck_ff    <= stuck_in;
         noentry_ff  <= noentry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff     <= req_func;
         wall_row_ff <= req_wall_row;
         wall_col_ff <= req_wall_col;
      end
      if (cmd.rsp_load) begin
         pos_row_ff <= cur_row_ff;
         pos_col_ff <= cur_col_ff;
         reached_ff <= done && !noentry_ff;
         rstuck_ff  <= stuck_ff;
      end
   end

   assign status.func      = func_ff;
   assign status.started   = started_ff;
   assign status.done      = done;
   assign status.scan_last = ({1'b0, scan_col_ff} == (ncols - 9'd1));
   assign status.cell_wall = rd_data;
   assign status.nb_valid  = nb_valid;
   assign status.try_last  = (try_ff == 2'd3);
   assign status.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));

   assign rsp_pos_row      = pos_row_ff;
   assign rsp_pos_col      = pos_col_ff;
   assign rsp_reached_exit = reached_ff;
   assign rsp_stuck        = rstuck_ff;

endmodule

// ----- rtl/rhmw_ctrl.sv -----
module rhmw_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rhmw_pkg::rhmw_status_type status,
   output rhmw_pkg::rhmw_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_TRY,
      S_TRY_CHK,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.func)
               rhmw_pkg::FUNC_MARK: begin
                  cmd.mark_wr = 1'b1;
                  state_in    = S_IDLE;
               end
               rhmw_pkg::FUNC_CLEAR: begin
                  cmd.restart = 1'b1;
                  state_in    = S_CLEAR;
               end
               rhmw_pkg::FUNC_STEP: begin
                  if (!status.started) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN_RD;
                  end else if (status.done) begin
                     state_in = S_OUT;
                  end else begin
                     cmd.try_start = 1'b1;
                     state_in      = S_TRY;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!status.cell_wall) begin
               cmd.commit_entry = 1'b1;
               state_in         = S_OUT;
            end else if (status.scan_last) begin
               cmd.set_noentry = 1'b1;
               state_in        = S_OUT;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_TRY: begin
            if (status.nb_valid) begin
               cmd.rd_nb = 1'b1;
               state_in  = S_TRY_CHK;
            end else if (status.try_last) begin
               cmd.set_stuck = 1'b1;
               state_in      = S_OUT;
            end else begin
               cmd.try_next = 1'b1;
            end
         end
         S_TRY_CHK: begin
            if (!status.cell_wall) begin
               cmd.commit_move = 1'b1;
               state_in        = S_OUT;
            end else if (status.try_last) begin
               cmd.set_stuck = 1'b1;
               state_in      = S_OUT;
            end else begin
               cmd.try_next = 1'b1;
               state_in     = S_TRY;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- dv/right_hand_maze_walker_tb.sv -----
`timescale 1ns / 100ps

module right_hand_maze_walker_tb;

   localparam int  HALF_PERIOD = 2;
   localparam int  RESET_CYCLES = 5;
   // the clearing sweep holds req_stall with nothing moving
   localparam int  QUIET_LIMIT = 200000;
   localparam int  HOLD_CYCLES = 400;
   localparam int  ITEM_BUDGET = 900;
   // marks finish in the decode state after their beat; give a good margin
   localparam int  SETTLE_CYCLES = 16;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic       at_exit;
      logic       stuck;
   } walk_pos_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [1:0]    fn;
      logic [7:0]    r;
      logic [7:0]    c;
      logic          reg_idx;
      logic [8:0]    value;
      bit            known;
      walk_pos_type  want;
   } plan_row_type;

   // ---------------------------------------------------------------- DUT
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [7:0]  req_wall_row = '0;
   logic [7:0]  req_wall_col = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pos_row;
   logic [7:0]  rsp_pos_col;
   logic        rsp_reached_exit;
   logic        rsp_stuck;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   right_hand_maze_walker dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_wall_row(req_wall_row),
      .req_wall_col(req_wall_col),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_row(rsp_pos_row),
      .rsp_pos_col(rsp_pos_col),
      .rsp_reached_exit(rsp_reached_exit),
      .rsp_stuck(rsp_stuck),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- walker mirror
   // Own copy of the maze and the walker; updated as each request beat is taken.
   bit         wall_bits [65536];
   logic [7:0] at_row = '0;
   logic [7:0] at_col = '0;
   logic [1:0] heading = rhmw_pkg::HEAD_SOUTH;
   bit         entered = 1'b0;
   logic [8:0] rows_reg = rhmw_pkg::SIZE_RESET;
   logic [8:0] cols_reg = rhmw_pkg::SIZE_RESET;

   walk_pos_type pos_due[$];    // positions still owed by the block
   plan_row_type plan[$];
   int         fails = 0;
   int         idle_pct = 28;
   bit         hold_ask = 1'b0;
   int         hold_left = 0;
   int         quiet = 0;

   // register sizes saturate to 1 .. 256
   function automatic int span_of(input logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'd256) return 256;
      return int'(v);
   endfunction

   task automatic walker_advance(input logic [1:0] fn, input logic [7:0] wr,
                                 input logic [7:0] wc, output bit gives,
                                 output walk_pos_type p);
      int         nrows, ncols, tr, tc, c, k;
      bit         moved, found, walled;
      logic [1:0] h;
      logic [1:0] turns [4];
      turns[0] = rhmw_pkg::TURN_RIGHT;
      turns[1] = rhmw_pkg::TURN_AHEAD;
      turns[2] = rhmw_pkg::TURN_LEFT;
      turns[3] = rhmw_pkg::TURN_BACK;
      gives  = 1'b0;
      p      = '0;
      walled = 1'b0;
      nrows  = span_of(rows_reg);
      ncols  = span_of(cols_reg);
      case (fn)
         rhmw_pkg::FUNC_MARK: begin
            wall_bits[{wr, wc}] = 1'b1;
         end
         rhmw_pkg::FUNC_CLEAR: begin
            foreach (wall_bits[i]) wall_bits[i] = 1'b0;
            at_row  = '0;
            at_col  = '0;
            heading = rhmw_pkg::HEAD_SOUTH;
            entered = 1'b0;
         end
         rhmw_pkg::FUNC_STEP: begin
            gives = 1'b1;
            if (!entered) begin
               // entry: first open cell of row 0, lowest column first
               found = 1'b0;
               for (c = 0; c < ncols && !found; c++) begin
                  if (!wall_bits[c]) begin
                     found  = 1'b1;
                     at_col = c[7:0];
                  end
               end
               if (found) begin
                  at_row  = '0;
                  heading = rhmw_pkg::HEAD_SOUTH;
                  entered = 1'b1;
               end
            end else if (at_row < nrows - 1) begin
               moved = 1'b0;
               for (k = 0; k < 4 && !moved; k++) begin
                  h  = heading + turns[k];
                  tr = at_row;
                  tc = at_col;
                  case (h)
                     rhmw_pkg::HEAD_SOUTH: tr = tr + 1;
                     rhmw_pkg::HEAD_WEST:  tc = tc - 1;
                     rhmw_pkg::HEAD_NORTH: tr = tr - 1;
                     default:              tc = tc + 1;
                  endcase
                  if (tr >= 0 && tc >= 0 && tr < nrows && tc < ncols &&
                      !wall_bits[tr * 256 + tc]) begin
                     at_row  = tr[7:0];
                     at_col  = tc[7:0];
                     heading = h;
                     moved   = 1'b1;
                  end
               end
               walled = !moved;
            end
            if (!entered) begin
               p = {8'd0, 8'd0, 1'b0, 1'b1};
            end else begin
               p.row     = at_row;
               p.col     = at_col;
               p.at_exit = (at_row >= nrows - 1);
               p.stuck   = walled;
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- request side
   // Offer one beat, with random gaps in front; returns at the edge that takes it.
   task automatic offer_item(input logic [1:0] fn, input logic [7:0] r,
                             input logic [7:0] c, input bit known,
                             input walk_pos_type fixed);
      bit           gives;
      walk_pos_type p;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_func     <= fn;
      req_wall_row <= r;
      req_wall_col <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      walker_advance(fn, r, c, gives, p);
      if (gives) pos_due.push_back(known ? fixed : p);
   endtask

   // Drop valid, wait for every owed position and for the block to go idle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pos_due.size() != 0) @(posedge clock);
      do @(posedge clock); while (req_stall !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a size register, then read it back.
   task automatic program_reg(input logic idx, input logic [8:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {23'd0, val};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (idx == rhmw_pkg::CSR_ROWS) rows_reg = val;
      else cols_reg = val;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[8:0] !== val) begin
         $error("prdata: expected %0d, got %0d", val, csr_prdata[8:0]);
         fails++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- response side
   // Random stall, or a long hold-off when asked; counted here, not in the driver.
   always @(negedge clock) begin
      if (hold_ask) begin
         hold_ask  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // Every response beat against the oldest owed position.
   always @(posedge clock) begin : check_rsp
      walk_pos_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pos_due.size() == 0) begin
            $error("response beat with no position owed");
            fails++;
         end else begin
            want = pos_due.pop_front();
            if (rsp_pos_row !== want.row) begin
               $error("pos_row: expected %0d, got %0d", want.row, rsp_pos_row);
               fails++;
            end
            if (rsp_pos_col !== want.col) begin
               $error("pos_col: expected %0d, got %0d", want.col, rsp_pos_col);
               fails++;
            end
            if (rsp_reached_exit !== want.at_exit) begin
               $error("reached_exit: expected %0d, got %0d", want.at_exit,
                      rsp_reached_exit);
               fails++;
            end
            if (rsp_stuck !== want.stuck) begin
               $error("stuck: expected %0d, got %0d", want.stuck, rsp_stuck);
               fails++;
            end
         end
      end
   end

   // Watchdog: cycles in a row with no beat on any port.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("right_hand_maze_walker verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- directed table
   task automatic plan_item(input logic [1:0] fn, input logic [7:0] r,
                            input logic [7:0] c);
      plan_row_type e;
      e       = '{kind: ROW_ITEM, default: '0};
      e.fn    = fn;
      e.r     = r;
      e.c     = c;
      plan.push_back(e);
   endtask

   task automatic plan_known(input logic [1:0] fn, input walk_pos_type want);
      plan_row_type e;
      e       = '{kind: ROW_ITEM, default: '0};
      e.fn    = fn;
      e.known = 1'b1;
      e.want  = want;
      plan.push_back(e);
   endtask

   task automatic plan_reg(input logic idx, input logic [8:0] val);
      plan_row_type e;
      e         = '{kind: ROW_CSR, default: '0};
      e.reg_idx = idx;
      e.value   = val;
      plan.push_back(e);
   endtask

   function automatic logic [8:0] pick_size(input bit is_col);
      if ($urandom_range(99) < 85)
         return is_col ? 9'($urandom_range(1, 24)) : 9'($urandom_range(2, 24));
      case ($urandom_range(6))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd2;
         3:       return 9'd255;
         4:       return 9'd256;
         5:       return 9'd257;
         default: return 9'd511;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      plan_row_type e;
      int           k, n, nr, nc, roll, issued, phase, clears_left;
      logic [8:0]   rv, cv;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fresh map at 256 x 256: enter at column 0, then walk south
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd0, 1'b0, 1'b0});
      plan_item(rhmw_pkg::FUNC_STEP, 8'd37, 8'd200);
      plan_item(rhmw_pkg::FUNC_MARK, 8'd255, 8'd255);
      plan_item(rhmw_pkg::FUNC_MARK, 8'd0, 8'd0);
      plan_item(FUNC_SPARE, 8'd255, 8'd255);        // unused code, ignored
      plan_item(rhmw_pkg::FUNC_STEP, 8'd0, 8'd0);
      // grid shrunk under the walker: it sits below the last row
      plan_reg(rhmw_pkg::CSR_ROWS, 9'd2);
      plan_known(rhmw_pkg::FUNC_STEP, {8'd2, 8'd0, 1'b1, 1'b0});
      // one usable column, walled: no way in
      plan_item(rhmw_pkg::FUNC_CLEAR, 8'd0, 8'd0);
      plan_reg(rhmw_pkg::CSR_COLS, 9'd1);
      plan_item(rhmw_pkg::FUNC_MARK, 8'd0, 8'd0);
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd0, 1'b0, 1'b1});
      plan_reg(rhmw_pkg::CSR_COLS, 9'd0);           // saturates to one column
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd0, 1'b0, 1'b1});
      // single row: the entry is already the exit, then it stays put
      plan_reg(rhmw_pkg::CSR_ROWS, 9'd0);
      plan_reg(rhmw_pkg::CSR_COLS, 9'd511);
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd1, 1'b1, 1'b0});
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd1, 1'b1, 1'b0});
      // walled in on all four sides, top edge included
      plan_reg(rhmw_pkg::CSR_ROWS, 9'd511);
      plan_item(rhmw_pkg::FUNC_MARK, 8'd1, 8'd1);
      plan_item(rhmw_pkg::FUNC_MARK, 8'd0, 8'd2);
      plan_known(rhmw_pkg::FUNC_STEP, {8'd0, 8'd1, 1'b0, 1'b1});

      for (k = 0; k < plan.size(); k++) begin
         e = plan[k];
         if (e.kind == ROW_CSR) begin
            settle();
            program_reg(e.reg_idx, e.value);
         end else begin
            offer_item(e.fn, e.r, e.c, e.known, e.want);
         end
      end

      // Random phases: new sizes each time, now and then a fresh maze,
      // walls sprinkled in, mostly steps.
      issued      = 0;
      phase       = 0;
      clears_left = 6;
      while (issued < ITEM_BUDGET) begin
         settle();
         idle_pct = (phase == 3) ? 0 : 28;          // one calm stretch
         rv = pick_size(1'b0);
         cv = pick_size(1'b1);
         program_reg(rhmw_pkg::CSR_ROWS, rv);
         program_reg(rhmw_pkg::CSR_COLS, cv);
         nr = span_of(rv);
         nc = span_of(cv);
         if (clears_left > 0 && (phase == 0 || $urandom_range(4) == 0)) begin
            offer_item(rhmw_pkg::FUNC_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
            clears_left--;
            issued++;
         end
         if (phase == 1) begin
            // receiver holds off while steps keep coming, so the block backs up
            hold_ask = 1'b1;
            idle_pct = 0;
            repeat (10) begin
               offer_item(rhmw_pkg::FUNC_STEP, 8'($urandom), 8'($urandom), 1'b0, '0);
               issued++;
            end
            settle();
            idle_pct = 28;
         end
         repeat ($urandom_range(6)) begin
            offer_item(rhmw_pkg::FUNC_MARK, 8'($urandom_range(nr - 1)),
                       8'($urandom_range(nc - 1)), 1'b0, '0);
            issued++;
         end
         n = (phase == 3) ? 80 : $urandom_range(15, 40);
         for (k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 62) begin
               offer_item(rhmw_pkg::FUNC_STEP, 8'($urandom), 8'($urandom), 1'b0, '0);
               issued++;
            end else if (roll < 90) begin
               offer_item(rhmw_pkg::FUNC_MARK, 8'($urandom_range(nr - 1)),
                          8'($urandom_range(nc - 1)), 1'b0, '0);
               issued++;
            end else if (roll < 96) begin
               offer_item(rhmw_pkg::FUNC_MARK, 8'($urandom), 8'($urandom), 1'b0, '0);
               issued++;
            end else begin
               offer_item(FUNC_SPARE, 8'($urandom), 8'($urandom), 1'b0, '0);
            end
         end
         phase++;
      end

      settle();
      repeat (40) @(posedge clock);
      if (fails == 0) begin
         $display("right_hand_maze_walker verification clean");
      end else begin
         $display("right_hand_maze_walker verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rhmw_pkg.sv
rtl/rhmw_ram.sv
rtl/rhmw_dp.sv
rtl/rhmw_ctrl.sv
rtl/right_hand_maze_walker.sv
dv/right_hand_maze_walker_tb.sv
